/* hw/rtl/rclm_pkg.sv */
// Shared types, codes and constants for the rolling counter lease manager.
// Holds the request and response beat structs and the record CRC-32 function.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rclm_pkg;

  localparam int unsigned CTR_W = 29;
  localparam int unsigned GRANT_W = 28;
  localparam int unsigned ID_TAG_W = 12;

  localparam logic [31:0] REC_MAGIC = 32'h5247_444f;
  localparam logic [31:0] REC_VERSION = 32'h0000_0001;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] GEN_MAX = 32'hffff_ffff;
  localparam logic [31:0] GEN_FIRST = 32'h0000_0001;
  localparam logic [ID_TAG_W-1:0] ID_TAG = 12'h539;

  localparam logic [31:0] COUNTER_LIMIT = 32'h1000_0000;
  localparam logic [CTR_W-1:0] CTR_LIMIT = 29'h1000_0000;
  localparam logic [CTR_W-1:0] LEASE_SIZE = 29'd64;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PROVISION = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;
  localparam logic [1:0] KIND_ACK = 2'd3;

  localparam logic [1:0] RS_OK = 2'd0;
  localparam logic [1:0] RS_MISSING = 2'd1;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_GRANT = 2'd1;
  localparam logic [1:0] RK_COMMIT = 2'd2;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_UNPROVISIONED = 4'd1;
  localparam logic [3:0] ERR_INTERRUPTED = 4'd2;
  localparam logic [3:0] ERR_CORRUPT = 4'd3;
  localparam logic [3:0] ERR_EXHAUSTED = 4'd4;
  localparam logic [3:0] ERR_GEN_EXHAUSTED = 4'd5;
  localparam logic [3:0] ERR_COMMIT_FAILED = 4'd6;
  localparam logic [3:0] ERR_PROV_REFUSED = 4'd7;
  localparam logic [3:0] ERR_INVALID = 4'd8;
  localparam logic [3:0] ERR_NOT_READY = 4'd9;
  localparam logic [3:0] ERR_BUSY = 4'd10;

  typedef enum logic [1:0] {
    AWAIT_NONE,
    AWAIT_EXTEND,
    AWAIT_PROVISION
  } await_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] record_magic;
    logic [31:0] record_version;
    logic [31:0] record_identity;
    logic [31:0] record_lease_end;
    logic [31:0] record_generation;
    logic [31:0] record_crc;
    logic [1:0]  read_status;
    logic        write_pending;
    logic        commit_ok;
  } lease_req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [3:0]         error_code;
    logic [GRANT_W-1:0] granted_counter;
    logic               ready_flag;
    logic [31:0]        commit_identity;
    logic [CTR_W-1:0]   commit_lease_end;
    logic [31:0]        commit_generation;
    logic [31:0]        commit_crc;
  } lease_rsp_t;

  // Reflected CRC-32 over one little-endian word, one data bit per step.
  function automatic logic [31:0] crc_word(input logic [31:0] crc_in, input logic [31:0] w);
    logic [31:0] c;
    c = crc_in;
    for (int i = 0; i < 32; i++) begin
      c = (c >> 1) ^ (((c[0] ^ w[i]) == 1'b1) ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rclm_crc.sv */
// Record CRC-32 unit for the lease manager: magic, version, identity,
// lease end and generation, each little-endian. Uses rclm_pkg.
// The fixed first two words are folded into a constant at elaboration.
`timescale 1ns / 1ps
`default_nettype none

module rclm_crc (
  input  wire logic [31:0] identity,
  input  wire logic [31:0] lease_end,
  input  wire logic [31:0] generation,
  output logic      [31:0] crc
);
  import rclm_pkg::*;

  localparam logic [31:0] CRC_PREFIX = crc_word(crc_word(CRC_INIT, REC_MAGIC), REC_VERSION);

  assign crc = ~crc_word(crc_word(crc_word(CRC_PREFIX, identity), lease_end), generation);

endmodule

`default_nettype wire

/* hw/rtl/rclm_ctrl.sv */
// Lease state and per-beat decision logic of the lease manager.
// Holds the lease registers, decides each request and builds its response.
// Uses rclm_pkg and rclm_crc.
`timescale 1ns / 1ps
`default_nettype none

module rclm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire rclm_pkg::lease_req_t req,
  output rclm_pkg::lease_rsp_t     rsp
);
  import rclm_pkg::*;

  logic             lease_ready, lease_ready_next;
  logic [31:0]      identity_reg, identity_reg_next;
  logic [CTR_W-1:0] next_counter, next_counter_next;
  logic [CTR_W-1:0] lease_end, lease_end_next;
  logic [31:0]      generation_reg, generation_reg_next;
  await_t           awaiting, awaiting_next;
  logic [CTR_W-1:0] proposed_end, proposed_end_next;

  logic [CTR_W-1:0] remaining;
  logic [CTR_W-1:0] ext_end;
  logic [31:0]      crc_id;
  logic [31:0]      crc_end;
  logic [31:0]      crc_gen;
  logic [31:0]      crc_val;
  logic             id_ok;
  logic [3:0]       err;

  always_comb begin
    remaining = CTR_LIMIT - lease_end;
    ext_end = lease_end + ((remaining < LEASE_SIZE) ? remaining : LEASE_SIZE);
    id_ok = (req.record_identity[ID_TAG_W-1:0] == ID_TAG);
    crc_id = (req.kind == KIND_TAKE) ? identity_reg : req.record_identity;
    crc_end = (req.kind == KIND_TAKE) ? {3'b000, ext_end} : req.record_lease_end;
    if (req.kind == KIND_LOAD) begin
      crc_gen = req.record_generation;
    end else if (req.kind == KIND_PROVISION) begin
      crc_gen = GEN_FIRST;
    end else begin
      crc_gen = generation_reg + 32'd1;
    end
  end

  rclm_crc u_crc (
    .identity   (crc_id),
    .lease_end  (crc_end),
    .generation (crc_gen),
    .crc        (crc_val)
  );

  always_comb begin
    lease_ready_next = lease_ready;
    identity_reg_next = identity_reg;
    next_counter_next = next_counter;
    lease_end_next = lease_end;
    generation_reg_next = generation_reg;
    awaiting_next = awaiting;
    proposed_end_next = proposed_end;
    err = ERR_OK;
    rsp = '0;

    if (req.kind != KIND_ACK && awaiting != AWAIT_NONE) begin
      err = ERR_BUSY;
    end else begin
      case (req.kind)
        KIND_LOAD: begin
          lease_ready_next = 1'b0;
          if (req.read_status == RS_MISSING) begin
            err = req.write_pending ? ERR_INTERRUPTED : ERR_UNPROVISIONED;
          end else if (req.read_status != RS_OK || req.record_magic != REC_MAGIC ||
                       req.record_version != REC_VERSION || !id_ok ||
                       req.record_lease_end > COUNTER_LIMIT ||
                       req.record_generation == 32'd0 || req.record_crc != crc_val) begin
            err = ERR_CORRUPT;
          end else begin
            identity_reg_next = req.record_identity;
            next_counter_next = req.record_lease_end[CTR_W-1:0];
            lease_end_next = req.record_lease_end[CTR_W-1:0];
            generation_reg_next = req.record_generation;
            if (req.record_lease_end == COUNTER_LIMIT) begin
              err = ERR_EXHAUSTED;
            end else begin
              lease_ready_next = 1'b1;
            end
          end
        end
        KIND_PROVISION: begin
          if (req.read_status != RS_MISSING || req.write_pending) begin
            lease_ready_next = 1'b0;
            err = ERR_PROV_REFUSED;
          end else if (!id_ok || req.record_lease_end >= COUNTER_LIMIT) begin
            lease_ready_next = 1'b0;
            err = ERR_INVALID;
          end else begin
            identity_reg_next = req.record_identity;
            proposed_end_next = req.record_lease_end[CTR_W-1:0];
            awaiting_next = AWAIT_PROVISION;
            rsp.result_kind = RK_COMMIT;
            rsp.commit_identity = req.record_identity;
            rsp.commit_lease_end = req.record_lease_end[CTR_W-1:0];
            rsp.commit_generation = GEN_FIRST;
            rsp.commit_crc = crc_val;
          end
        end
        KIND_TAKE: begin
          if (!lease_ready) begin
            err = ERR_NOT_READY;
          end else if (next_counter >= CTR_LIMIT) begin
            lease_ready_next = 1'b0;
            err = ERR_EXHAUSTED;
          end else if (next_counter == lease_end) begin
            if (generation_reg == GEN_MAX) begin
              lease_ready_next = 1'b0;
              err = ERR_GEN_EXHAUSTED;
            end else begin
              proposed_end_next = ext_end;
              awaiting_next = AWAIT_EXTEND;
              rsp.result_kind = RK_COMMIT;
              rsp.commit_identity = identity_reg;
              rsp.commit_lease_end = ext_end;
              rsp.commit_generation = generation_reg + 32'd1;
              rsp.commit_crc = crc_val;
            end
          end else begin
            rsp.result_kind = RK_GRANT;
            rsp.granted_counter = next_counter[GRANT_W-1:0];
            next_counter_next = next_counter + 29'd1;
          end
        end
        KIND_ACK: begin
          awaiting_next = AWAIT_NONE;
          case (awaiting)
            AWAIT_EXTEND: begin
              if (!req.commit_ok) begin
                lease_ready_next = 1'b0;
                err = ERR_COMMIT_FAILED;
              end else begin
                lease_end_next = proposed_end;
                generation_reg_next = generation_reg + 32'd1;
                rsp.result_kind = RK_GRANT;
                rsp.granted_counter = next_counter[GRANT_W-1:0];
                next_counter_next = next_counter + 29'd1;
              end
            end
            AWAIT_PROVISION: begin
              if (!req.commit_ok) begin
                lease_ready_next = 1'b0;
                err = ERR_COMMIT_FAILED;
              end else begin
                next_counter_next = proposed_end;
                lease_end_next = proposed_end;
                generation_reg_next = GEN_FIRST;
                lease_ready_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    rsp.error_code = err;
    rsp.ready_flag = lease_ready_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_ready <= 1'b0;
      identity_reg <= '0;
      next_counter <= '0;
      lease_end <= '0;
      generation_reg <= '0;
      awaiting <= AWAIT_NONE;
      proposed_end <= '0;
    end else if (fire) begin
      lease_ready <= lease_ready_next;
      identity_reg <= identity_reg_next;
      next_counter <= next_counter_next;
      lease_end <= lease_end_next;
      generation_reg <= generation_reg_next;
      awaiting <= awaiting_next;
      proposed_end <= proposed_end_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rolling_counter_lease_manager.sv */
// Top level of the rolling counter lease manager: input register, lease
// decision logic and output register with valid/stall flow control.
// Uses rclm_pkg and rclm_ctrl.
//
//   channel   direction   payload       handshake
//   req       in          lease_req_t   req_valid / req_stall
//   rsp       out         lease_rsp_t   rsp_valid / rsp_stall
//
// One request beat is taken per cycle while req_stall is low, and each gives
// exactly one response beat. A beat is decided from the input register once
// the output register can take it; its response is loaded there and the lease
// state is updated together, ready for the next beat straight behind it.
// Reset clears the lease state and both valid flags.
// A stall on a valid rsp holds the output register and, once the input register is
// full, raises req_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module rolling_counter_lease_manager (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire rclm_pkg::lease_req_t req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rclm_pkg::lease_rsp_t      rsp
);
  import rclm_pkg::*;

  lease_req_t req_hold;
  logic       hold_valid;
  lease_rsp_t rsp_calc;
  logic       out_load;
  logic       fire;
  logic       hold_open;

  assign out_load = !rsp_valid || !rsp_stall;
  assign fire = hold_valid && out_load;
  assign hold_open = !hold_valid || fire;
  assign req_stall = !hold_open;

  rclm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req_hold),
    .rsp  (rsp_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (hold_open) begin
        hold_valid <= req_valid;
      end
      if (out_load) begin
        rsp_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_open && req_valid) begin
      req_hold <= req;
    end
    if (fire) begin
      rsp <= rsp_calc;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rclm_checker.sv */
// Port-level checks for the rolling counter lease manager, bound to the top.
// Watches only the top-level ports. Uses rclm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rclm_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_stall,
  input wire rclm_pkg::lease_req_t req,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_stall,
  input wire rclm_pkg::lease_rsp_t rsp
);
  import rclm_pkg::*;

  // An accepted beat reaches the output when the output is not held.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
    else $error("accepted beat did not reach the output");

  // A held response stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // A granted counter always comes with a usable lease and no error.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == RK_GRANT) |-> (rsp.ready_flag && rsp.error_code == ERR_OK))
    else $error("grant without a ready lease");

  // A commit request carries no error and no granted counter.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == RK_COMMIT) |->
      (rsp.error_code == ERR_OK && rsp.granted_counter == '0))
    else $error("malformed commit request");

endmodule

bind rolling_counter_lease_manager rclm_checker u_rclm_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the rolling counter lease manager: a stimulus table and then
// random load, provision, take and acknowledge beats, each predicted and checked in order.
// Depends on rclm_pkg and rolling_counter_lease_manager; needs nothing else.
`timescale 1ns / 1ps

module tb;
  import rclm_pkg::*;

  localparam logic [1:0] RS_READ_ERR = 2'd2;
  localparam logic [31:0] ID_GOOD = 32'h1234_5539;
  localparam logic [31:0] ID_HIGH = 32'hffff_f539;
  localparam int RANDOM_ITEMS = 550;

  typedef struct packed {
    logic       typed;
    lease_req_t req;
    lease_rsp_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  lease_req_t req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  lease_rsp_t rsp;

  logic             st_ready = 1'b0;
  logic [31:0]      st_identity = '0;
  logic [CTR_W-1:0] st_next = '0;
  logic [CTR_W-1:0] st_end = '0;
  logic [31:0]      st_gen = '0;
  await_t           st_await = AWAIT_NONE;
  logic [CTR_W-1:0] st_proposed = '0;

  lease_rsp_t expected_rsp[$];
  stim_row_t  stim_table[$];
  lease_rsp_t head_rsp;
  int         errors = 0;
  int         burst_left = 0;
  int         stall_cycle = 0;
  int         stall_mode = 0;

  rolling_counter_lease_manager DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] crc_add_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 4; i++) begin
      c = c ^ {24'h0, w[8*i +: 8]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] rec_crc32(input logic [31:0] id, input logic [31:0] lend,
                                            input logic [31:0] gen);
    logic [31:0] c;
    c = crc_add_word(CRC_INIT, REC_MAGIC);
    c = crc_add_word(c, REC_VERSION);
    c = crc_add_word(c, id);
    c = crc_add_word(c, lend);
    c = crc_add_word(c, gen);
    return ~c;
  endfunction

  function automatic lease_rsp_t commit_rsp(input logic [31:0] id, input logic [CTR_W-1:0] lend,
                                            input logic [31:0] gen);
    lease_rsp_t o;
    o = '0;
    o.result_kind = RK_COMMIT;
    o.commit_identity = id;
    o.commit_lease_end = lend;
    o.commit_generation = gen;
    o.commit_crc = rec_crc32(id, {3'b000, lend}, gen);
    return o;
  endfunction

  function automatic lease_rsp_t status_rsp(input logic [3:0] err, input logic rdy);
    lease_rsp_t o;
    o = '0;
    o.result_kind = RK_STATUS;
    o.error_code = err;
    o.ready_flag = rdy;
    return o;
  endfunction

  // Advances the lease state by one request beat and returns the response it gives.
  function automatic lease_rsp_t lease_decide(input lease_req_t r);
    lease_rsp_t       o;
    logic [3:0]       err;
    logic [CTR_W-1:0] rem;
    logic [CTR_W-1:0] ne;
    logic             was_prov;
    o = '0;
    err = ERR_OK;
    if (r.kind != KIND_ACK && st_await != AWAIT_NONE) begin
      err = ERR_BUSY;
    end else begin
      case (r.kind)
        KIND_LOAD: begin
          st_ready = 1'b0;
          if (r.read_status == RS_MISSING) begin
            err = r.write_pending ? ERR_INTERRUPTED : ERR_UNPROVISIONED;
          end else if (r.read_status != RS_OK || r.record_magic != REC_MAGIC ||
                       r.record_version != REC_VERSION ||
                       r.record_identity[ID_TAG_W-1:0] != ID_TAG ||
                       r.record_lease_end > COUNTER_LIMIT || r.record_generation == 32'h0 ||
                       r.record_crc != rec_crc32(r.record_identity, r.record_lease_end,
                                                 r.record_generation)) begin
            err = ERR_CORRUPT;
          end else begin
            st_identity = r.record_identity;
            st_next = r.record_lease_end[CTR_W-1:0];
            st_end = r.record_lease_end[CTR_W-1:0];
            st_gen = r.record_generation;
            if (r.record_lease_end == COUNTER_LIMIT) err = ERR_EXHAUSTED;
            else st_ready = 1'b1;
          end
        end
        KIND_PROVISION: begin
          if (r.read_status != RS_MISSING || r.write_pending) begin
            st_ready = 1'b0;
            err = ERR_PROV_REFUSED;
          end else if (r.record_identity[ID_TAG_W-1:0] != ID_TAG ||
                       r.record_lease_end >= COUNTER_LIMIT) begin
            st_ready = 1'b0;
            err = ERR_INVALID;
          end else begin
            st_identity = r.record_identity;
            st_proposed = r.record_lease_end[CTR_W-1:0];
            st_await = AWAIT_PROVISION;
            o = commit_rsp(r.record_identity, r.record_lease_end[CTR_W-1:0], GEN_FIRST);
          end
        end
        KIND_TAKE: begin
          if (!st_ready) begin
            err = ERR_NOT_READY;
          end else if (st_next >= CTR_LIMIT) begin
            st_ready = 1'b0;
            err = ERR_EXHAUSTED;
          end else if (st_next == st_end) begin
            if (st_gen == GEN_MAX) begin
              st_ready = 1'b0;
              err = ERR_GEN_EXHAUSTED;
            end else begin
              rem = CTR_LIMIT - st_end;
              ne = st_end + ((rem < LEASE_SIZE) ? rem : LEASE_SIZE);
              st_proposed = ne;
              st_await = AWAIT_EXTEND;
              o = commit_rsp(st_identity, ne, st_gen + 32'h1);
            end
          end else begin
            o.result_kind = RK_GRANT;
            o.granted_counter = st_next[GRANT_W-1:0];
            st_next = st_next + 29'd1;
          end
        end
        default: begin
          if (st_await != AWAIT_NONE) begin
            was_prov = (st_await == AWAIT_PROVISION);
            st_await = AWAIT_NONE;
            if (!r.commit_ok) begin
              st_ready = 1'b0;
              err = ERR_COMMIT_FAILED;
            end else if (was_prov) begin
              st_next = st_proposed;
              st_end = st_proposed;
              st_gen = GEN_FIRST;
              st_ready = 1'b1;
            end else begin
              st_end = st_proposed;
              st_gen = st_gen + 32'h1;
              o.result_kind = RK_GRANT;
              o.granted_counter = st_next[GRANT_W-1:0];
              st_next = st_next + 29'd1;
            end
          end
        end
      endcase
    end
    o.error_code = err;
    o.ready_flag = st_ready;
    return o;
  endfunction

  function automatic lease_req_t mk_req(input logic [1:0] kind, input logic [31:0] magic,
                                        input logic [31:0] ver, input logic [31:0] id,
                                        input logic [31:0] lend, input logic [31:0] gen,
                                        input logic [31:0] crc, input logic [1:0] status,
                                        input logic pend, input logic ok);
    lease_req_t r;
    r.kind = kind;
    r.record_magic = magic;
    r.record_version = ver;
    r.record_identity = id;
    r.record_lease_end = lend;
    r.record_generation = gen;
    r.record_crc = crc;
    r.read_status = status;
    r.write_pending = pend;
    r.commit_ok = ok;
    return r;
  endfunction

  function automatic lease_req_t good_load(input logic [31:0] id, input logic [31:0] lend,
                                           input logic [31:0] gen);
    return mk_req(KIND_LOAD, REC_MAGIC, REC_VERSION, id, lend, gen, rec_crc32(id, lend, gen),
                  RS_OK, 1'b0, 1'b0);
  endfunction

  function automatic lease_req_t prov_req(input logic [1:0] status, input logic pend,
                                          input logic [31:0] id, input logic [31:0] lend);
    return mk_req(KIND_PROVISION, '0, '0, id, lend, '0, '0, status, pend, 1'b0);
  endfunction

  function automatic lease_req_t take_req();
    return mk_req(KIND_TAKE, '0, '0, '0, '0, '0, '0, RS_OK, 1'b0, 1'b0);
  endfunction

  function automatic lease_req_t ack_req(input logic ok);
    return mk_req(KIND_ACK, '0, '0, '0, '0, '0, '0, RS_OK, 1'b0, ok);
  endfunction

  function automatic lease_req_t rand_req();
    lease_req_t  r;
    logic [31:0] w;
    w = $urandom;
    r.kind = w[1:0];
    r.read_status = w[3:2];
    r.write_pending = w[4];
    r.commit_ok = w[5];
    r.record_magic = $urandom;
    r.record_version = $urandom;
    r.record_identity = $urandom;
    r.record_lease_end = $urandom;
    r.record_generation = $urandom;
    r.record_crc = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] rand_lend(input logic [31:0] top);
    if ($urandom_range(0, 3) == 0) return top - $urandom_range(0, 130);
    return $urandom_range(0, 5000);
  endfunction

  task automatic add_row(input lease_req_t r, input logic typed, input lease_rsp_t w);
    stim_row_t row;
    row.typed = typed;
    row.req = r;
    row.want = w;
    stim_table.push_back(row);
  endtask

  task automatic send_beat(input lease_req_t r, input logic typed, input lease_rsp_t w);
    int gap;
    lease_rsp_t pred;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = lease_decide(r);
    expected_rsp.push_back(typed ? w : pred);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 48 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 1) == 1);
      2: rsp_stall <= ((stall_cycle % 7) < 5);
      default: rsp_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: response beat with nothing expected, got %h", $time, rsp);
        errors = errors + 1;
      end else begin
        head_rsp = expected_rsp.pop_front();
        check_field("result_kind", 32'(head_rsp.result_kind), 32'(rsp.result_kind));
        check_field("error_code", 32'(head_rsp.error_code), 32'(rsp.error_code));
        check_field("granted_counter", 32'(head_rsp.granted_counter),
                    32'(rsp.granted_counter));
        check_field("ready_flag", 32'(head_rsp.ready_flag), 32'(rsp.ready_flag));
        check_field("commit_identity", head_rsp.commit_identity, rsp.commit_identity);
        check_field("commit_lease_end", 32'(head_rsp.commit_lease_end),
                    32'(rsp.commit_lease_end));
        check_field("commit_generation", head_rsp.commit_generation, rsp.commit_generation);
        check_field("commit_crc", head_rsp.commit_crc, rsp.commit_crc);
      end
    end
  end

  initial begin : stimulus
    lease_req_t  r;
    lease_req_t  rec;
    int          counted;
    int          pick;
    int unsigned bit_ix;

    rec = good_load(ID_GOOD, 32'd100, 32'd7);
    rec.read_status = RS_READ_ERR;
    add_row(take_req(), 1'b1, status_rsp(ERR_NOT_READY, 1'b0));
    add_row(ack_req(1'b1), 1'b1, status_rsp(ERR_OK, 1'b0));
    add_row(mk_req(KIND_LOAD, '0, '0, '0, '0, '0, '0, RS_MISSING, 1'b0, 1'b0), 1'b1,
            status_rsp(ERR_UNPROVISIONED, 1'b0));
    add_row(mk_req(KIND_LOAD, '0, '0, '0, '0, '0, '0, RS_MISSING, 1'b1, 1'b0), 1'b1,
            status_rsp(ERR_INTERRUPTED, 1'b0));
    add_row(rec, 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    rec = good_load(ID_GOOD, 32'd100, 32'd7);
    rec.record_magic = 32'hffff_ffff;
    add_row(rec, 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    rec = good_load(ID_GOOD, 32'd100, 32'd7);
    rec.record_version = 32'hffff_ffff;
    add_row(rec, 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    rec = good_load(ID_GOOD, 32'd100, 32'd7);
    rec.record_crc = ~rec.record_crc;
    add_row(rec, 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    add_row(good_load(ID_GOOD, 32'd100, 32'd0), 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    add_row(good_load(ID_GOOD, COUNTER_LIMIT + 32'd1, 32'd3), 1'b1,
            status_rsp(ERR_CORRUPT, 1'b0));
    add_row(good_load(32'h0, 32'd100, 32'd3), 1'b1, status_rsp(ERR_CORRUPT, 1'b0));
    add_row(prov_req(RS_OK, 1'b0, ID_GOOD, 32'd0), 1'b1, status_rsp(ERR_PROV_REFUSED, 1'b0));
    add_row(prov_req(RS_MISSING, 1'b0, 32'hffff_ffff, 32'd0), 1'b1,
            status_rsp(ERR_INVALID, 1'b0));
    add_row(prov_req(RS_MISSING, 1'b0, ID_GOOD, COUNTER_LIMIT), 1'b1,
            status_rsp(ERR_INVALID, 1'b0));
    add_row(prov_req(RS_MISSING, 1'b0, ID_GOOD, 32'd0), 1'b0, '0);
    add_row(take_req(), 1'b1, status_rsp(ERR_BUSY, 1'b0));
    add_row(ack_req(1'b0), 1'b1, status_rsp(ERR_COMMIT_FAILED, 1'b0));
    add_row(prov_req(RS_MISSING, 1'b0, ID_HIGH, COUNTER_LIMIT - 32'd1), 1'b0, '0);
    add_row(ack_req(1'b1), 1'b1, status_rsp(ERR_OK, 1'b1));
    add_row(take_req(), 1'b0, '0);
    add_row(ack_req(1'b1), 1'b0, '0);
    add_row(take_req(), 1'b1, status_rsp(ERR_EXHAUSTED, 1'b0));
    add_row(good_load(ID_HIGH, COUNTER_LIMIT, GEN_MAX), 1'b1, status_rsp(ERR_EXHAUSTED, 1'b0));
    add_row(good_load(ID_GOOD, 32'd0, GEN_MAX), 1'b1, status_rsp(ERR_OK, 1'b1));
    add_row(take_req(), 1'b1, status_rsp(ERR_GEN_EXHAUSTED, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_beat(stim_table[i].req, stim_table[i].typed,
                                      stim_table[i].want);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = rand_req();
      pick = $urandom_range(0, 9);
      if (st_await != AWAIT_NONE) begin
        if (pick < 8) begin
          r.kind = KIND_ACK;
          r.commit_ok = ($urandom_range(0, 9) != 0);
        end
      end else if (pick < 7) begin
        if (st_ready && pick < 6) begin
          r.kind = KIND_TAKE;
        end else if (pick < 4 || st_ready) begin
          rec = good_load({r.record_identity[31:ID_TAG_W], ID_TAG}, rand_lend(COUNTER_LIMIT),
                          ($urandom_range(0, 7) == 0) ? GEN_MAX - $urandom_range(0, 1)
                                                      : r.record_generation);
          rec.write_pending = r.write_pending;
          rec.commit_ok = r.commit_ok;
          if ($urandom_range(0, 9) == 0) begin
            bit_ix = $urandom_range(0, $bits(lease_req_t) - 1);
            rec[bit_ix] = ~rec[bit_ix];
          end
          r = rec;
        end else begin
          r.kind = KIND_PROVISION;
          if ($urandom_range(0, 7) != 0) begin
            r.read_status = RS_MISSING;
            r.write_pending = 1'b0;
          end
          if ($urandom_range(0, 7) != 0) r.record_identity[ID_TAG_W-1:0] = ID_TAG;
          if ($urandom_range(0, 7) != 0) r.record_lease_end = rand_lend(COUNTER_LIMIT - 32'd1);
        end
      end
      if (r.kind != KIND_ACK || st_await != AWAIT_NONE) counted = counted + 1;
      send_beat(r, 1'b0, '0);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
